[sv/matrix_inverse_3x3_defines.svh]
// Assertion macros for the 3x3 matrix inverse block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH

// same-cycle implication
`define MI3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/mi3_pkg.sv]
// Types and constants for the 3x3 matrix inverse block.
// No dependencies; used by every module of the block.
package mi3_pkg;

  typedef struct packed {
    logic signed [15:0] a00;
    logic signed [15:0] a01;
    logic signed [15:0] a02;
    logic signed [15:0] a10;
    logic signed [15:0] a11;
    logic signed [15:0] a12;
    logic signed [15:0] a20;
    logic signed [15:0] a21;
    logic signed [15:0] a22;
  } mi3_in_t;

  typedef struct packed {
    logic signed [31:0] inv00;
    logic signed [31:0] inv01;
    logic signed [31:0] inv02;
    logic signed [31:0] inv10;
    logic signed [31:0] inv11;
    logic signed [31:0] inv12;
    logic signed [31:0] inv20;
    logic signed [31:0] inv21;
    logic signed [31:0] inv22;
    logic               singular;
  } mi3_out_t;

  // front end result: cofactor magnitudes/signs per lane, determinant
  typedef struct packed {
    logic [8:0][31:0] cmag;
    logic [8:0]       cneg;
    logic [47:0]      dmag;
    logic             dneg;
    logic             sing;
  } mi3_front_t;

  localparam int unsigned FRONT_LAT = 5;
  localparam int unsigned QBITS     = 33;
  localparam int unsigned LANE_LAT  = QBITS + 2;
  localparam int unsigned PIPE_DEPTH = FRONT_LAT + LANE_LAT;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

endpackage

[sv/mi3_front.sv]
// Front end: cofactors and row-0 cofactor expansion determinant, five register stages.
// Depends on mi3_pkg.
module mi3_front (
  input  logic                clk,
  input  logic                en,
  input  mi3_pkg::mi3_in_t    in_data,
  output mi3_pkg::mi3_front_t front
);
  import mi3_pkg::*;

  mi3_in_t            in_r;
  logic signed [15:0] a      [3][3];
  logic signed [31:0] pp_r   [3][3];
  logic signed [31:0] pq_r   [3][3];
  logic signed [15:0] a0_r   [3];
  logic signed [32:0] cof_r  [3][3];
  logic signed [15:0] a0b_r  [3];
  logic signed [32:0] cofb_r [3][3];
  logic signed [47:0] dp_r   [3];
  logic signed [48:0] dsum;
  mi3_front_t         front_r;
  mi3_front_t         front_nxt;

  assign a[0][0] = in_r.a00;
  assign a[0][1] = in_r.a01;
  assign a[0][2] = in_r.a02;
  assign a[1][0] = in_r.a10;
  assign a[1][1] = in_r.a11;
  assign a[1][2] = in_r.a12;
  assign a[2][0] = in_r.a20;
  assign a[2][1] = in_r.a21;
  assign a[2][2] = in_r.a22;

  // input register
  always_ff @(posedge clk) begin
    if (en) in_r <= in_data;
  end

  // 2x2 minor products, cyclic indexing carries the cofactor sign
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        a0_r[r] <= a[0][r];
        for (int c = 0; c < 3; c++) begin
          pp_r[r][c] <= a[(r+1)%3][(c+1)%3] * a[(r+2)%3][(c+2)%3];
          pq_r[r][c] <= a[(r+1)%3][(c+2)%3] * a[(r+2)%3][(c+1)%3];
        end
      end
    end
  end

  // cofactors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        a0b_r[r] <= a0_r[r];
        for (int c = 0; c < 3; c++) begin
          cof_r[r][c] <= 33'(pp_r[r][c]) - 33'(pq_r[r][c]);
        end
      end
    end
  end

  // row-0 expansion products of the determinant
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dp_r[c] <= 48'(a0b_r[c] * cof_r[0][c]);
        for (int r = 0; r < 3; r++) cofb_r[r][c] <= cof_r[r][c];
      end
    end
  end

  // determinant sum, magnitudes and signs; lane i*3+j takes cofactor (j,i)
  assign dsum = 49'(dp_r[0]) + 49'(dp_r[1]) + 49'(dp_r[2]);

  always_comb begin
    front_nxt.dneg = dsum[48];
    front_nxt.dmag = dsum[48] ? 48'(-dsum) : dsum[47:0];
    front_nxt.sing = (dsum == '0);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        front_nxt.cneg[i*3+j] = cofb_r[j][i][32];
        front_nxt.cmag[i*3+j] = cofb_r[j][i][32] ? 32'(-cofb_r[j][i])
                                                  : cofb_r[j][i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) front_r <= front_nxt;
  end

  assign front = front_r;

endmodule

[sv/mi3_div_step.sv]
// One restoring division step: shift in a numerator bit, trial subtract.
// Depends on mi3_pkg.
module mi3_div_step (
  input  logic                    clk,
  input  logic                    en,
  input  logic [47:0]             rem_in,
  input  logic [mi3_pkg::QBITS-1:0] qn_in,
  input  logic [47:0]             den_in,
  output logic [47:0]             rem_out,
  output logic [mi3_pkg::QBITS-1:0] qn_out
);
  import mi3_pkg::*;

  logic [48:0]       trial;
  logic              fits;
  logic [47:0]       rem_nxt;
  logic [QBITS-1:0]  qn_nxt;
  logic [47:0]       rem_r;
  logic [QBITS-1:0]  qn_r;

  // qn holds unused numerator bits on top, quotient bits at the bottom
  assign trial   = {rem_in, qn_in[QBITS-1]};
  assign fits    = (trial >= {1'b0, den_in});
  assign rem_nxt = fits ? 48'(trial - {1'b0, den_in}) : trial[47:0];
  assign qn_nxt  = {qn_in[QBITS-2:0], fits};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      qn_r  <= qn_nxt;
    end
  end

  assign rem_out = rem_r;
  assign qn_out  = qn_r;

endmodule

[sv/mi3_lane.sv]
// One output lane: rounded quotient |C|*2^24/|D| by a pipelined divider,
// then sign and saturation. Depends on mi3_pkg and mi3_div_step.
module mi3_lane (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] cmag,
  input  logic        neg,
  input  logic        sing,
  input  logic [47:0] dmag,
  output logic [31:0] res
);
  import mi3_pkg::*;

  logic [55:0]      num;
  logic [47:0]      rem   [QBITS+1];
  logic [QBITS-1:0] qn    [QBITS+1];
  logic [47:0]      den_r [QBITS+1];
  logic             neg_r [QBITS+1];
  logic             zero_r[QBITS+1];
  logic             ovf_r [QBITS+1];
  logic [QBITS-1:0] q;
  logic [31:0]      res_nxt;
  logic [31:0]      res_r;

  // numerator with half the divisor added for round-to-nearest
  assign num = {cmag, 24'b0} + 56'(dmag[47:1]);

  // setup: high numerator bits seed the remainder; quotient >= 2^33 saturates
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]    <= 48'(num[55:QBITS]);
      qn[0]     <= num[QBITS-1:0];
      den_r[0]  <= dmag;
      neg_r[0]  <= neg;
      zero_r[0] <= sing;
      ovf_r[0]  <= (48'(num[55:QBITS]) >= dmag);
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    mi3_div_step u_step (
      .clk    (clk),
      .en     (en),
      .rem_in (rem[k]),
      .qn_in  (qn[k]),
      .den_in (den_r[k]),
      .rem_out(rem[k+1]),
      .qn_out (qn[k+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k+1]  <= den_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        ovf_r[k+1]  <= ovf_r[k];
      end
    end
  end

  // sign and saturation
  assign q = qn[QBITS];

  always_comb begin
    if (zero_r[QBITS]) begin
      res_nxt = '0;
    end else if (neg_r[QBITS]) begin
      res_nxt = (ovf_r[QBITS] || q > {1'b0, SAT_MIN}) ? SAT_MIN : 32'(-q);
    end else begin
      res_nxt = (ovf_r[QBITS] || q > {1'b0, SAT_MAX}) ? SAT_MAX : q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

[sv/matrix_inverse_3x3.sv]
// Channel | Dir | Signals                       | Content
// in      | in  | in_valid, in_ready, in_data   | 3x3 matrix, signed Q8.8 entries
// out     | out | out_valid, out_ready, out_data| inverse, signed Q16.16, singular flag
//
// One matrix is taken per cycle when the output is not stalled.
// The depth is set by the 33-step restoring divider in each of the nine lanes.
// A stalled output register freezes the whole pipeline; in_ready follows it.
// Reset (synchronous, rst_n low) clears the valid bits only.
//
// Top level: front end (cofactors, determinant) and nine divider lanes.
// Depends on mi3_pkg, mi3_front, mi3_lane and the assertion header.
`include "matrix_inverse_3x3_defines.svh"

module matrix_inverse_3x3 (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mi3_pkg::mi3_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mi3_pkg::mi3_out_t out_data
);
  import mi3_pkg::*;

  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;
  mi3_front_t            front;
  logic [31:0]           res  [9];
  logic                  sing_r [LANE_LAT];
  logic                  ent_zero;

  // pipeline advances unless the output holds an untaken result
  assign adv      = !vld_r[PIPE_DEPTH-1] || out_ready;
  assign in_ready = adv;

  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  mi3_front u_front (
    .clk    (clk),
    .en     (adv),
    .in_data(in_data),
    .front  (front)
  );

  for (genvar l = 0; l < 9; l++) begin : g_lane
    mi3_lane u_lane (
      .clk (clk),
      .en  (adv),
      .cmag(front.cmag[l]),
      .neg (front.cneg[l] ^ front.dneg),
      .sing(front.sing),
      .dmag(front.dmag),
      .res (res[l])
    );
  end

  // singular flag travels alongside the lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      sing_r[0] <= front.sing;
      for (int k = 1; k < LANE_LAT; k++) sing_r[k] <= sing_r[k-1];
    end
  end

  // merge lane results
  assign out_valid         = vld_r[PIPE_DEPTH-1];
  assign out_data.inv00    = res[0];
  assign out_data.inv01    = res[1];
  assign out_data.inv02    = res[2];
  assign out_data.inv10    = res[3];
  assign out_data.inv11    = res[4];
  assign out_data.inv12    = res[5];
  assign out_data.inv20    = res[6];
  assign out_data.inv21    = res[7];
  assign out_data.inv22    = res[8];
  assign out_data.singular = sing_r[LANE_LAT-1];

  // sample of entries that must be zero on a singular result
  assign ent_zero = (out_data.inv00 == '0) && (out_data.inv11 == '0) &&
                    (out_data.inv22 == '0) && (out_data.inv01 == '0);

  `MI3_ASSERT_NOW(a_sing_zero, out_valid && out_data.singular, ent_zero, "singular result with nonzero entries")

  `MI3_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_r[0], "accepted matrix did not enter pipeline")

  `MI3_ASSERT_NEXT(a_stall_freezes, !in_ready, $stable(vld_r), "pipeline moved while stalled")

endmodule

[tb/mi3_checker.sv]
// Checker for the 3x3 matrix inverse: watches both channels, predicts each inverse
// and compares it with the transfer on the result channel. Depends on mi3_pkg.
`timescale 1ns / 100ps

module mi3_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  mi3_pkg::mi3_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  mi3_pkg::mi3_out_t out_data,
  output int                err_count,
  output int                pending
);
  import mi3_pkg::*;

  mi3_out_t inverse_q[$];

  // rounded, saturated Q16.16 quotient of a cofactor by the determinant
  function automatic logic signed [31:0] q16_div(longint cof, longint det);
    logic [63:0] num, den, q;
    logic        neg;
    num = (cof < 0 ? -cof : cof);
    num = num << 24;
    den = (det < 0 ? -det : det);
    q = (num + (den >> 1)) / den;
    neg = (cof < 0) != (det < 0);
    if (q == 0) return 0;
    if (neg) begin
      if (q > 64'h8000_0000) return SAT_MIN;
      return -$signed(q[31:0]);
    end
    if (q > 64'h7FFF_FFFF) return SAT_MAX;
    return q[31:0];
  endfunction

  function automatic mi3_out_t predict_inverse(mi3_in_t m);
    longint a[3][3];
    longint cof[3][3];
    longint det;
    logic signed [31:0] v[9];
    mi3_out_t res;
    a[0][0] = m.a00; a[0][1] = m.a01; a[0][2] = m.a02;
    a[1][0] = m.a10; a[1][1] = m.a11; a[1][2] = m.a12;
    a[2][0] = m.a20; a[2][1] = m.a21; a[2][2] = m.a22;
    det = a[0][0]*a[1][1]*a[2][2] + a[0][1]*a[1][2]*a[2][0] + a[0][2]*a[1][0]*a[2][1]
        - a[2][0]*a[1][1]*a[0][2] - a[1][0]*a[0][1]*a[2][2] - a[0][0]*a[2][1]*a[1][2];
    // cyclic indexing carries the cofactor sign
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        cof[r][c] = a[(r+1)%3][(c+1)%3] * a[(r+2)%3][(c+2)%3]
                  - a[(r+1)%3][(c+2)%3] * a[(r+2)%3][(c+1)%3];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        v[r*3+c] = (det == 0) ? 32'sd0 : q16_div(cof[c][r], det);
    res = '{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], det == 0};
    return res;
  endfunction

  assign pending = inverse_q.size();

  initial err_count = 0;

  // predict on input transfer, compare on result transfer
  always @(posedge clk) begin
    mi3_out_t exp_r;
    if (rst_n) begin
      if (in_valid && in_ready) inverse_q.push_back(predict_inverse(in_data));
      if (out_valid && out_ready) begin
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %h", $time, out_data);
          err_count++;
        end else begin
          exp_r = inverse_q.pop_front();
          if (exp_r !== out_data) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, out_data);
            err_count++;
          end
        end
      end
    end
  end
endmodule

[tb/matrix_inverse_3x3_test.sv]
// Stimulus and verdict for the 3x3 matrix inverse block.
// Depends on mi3_pkg, matrix_inverse_3x3 and mi3_checker.
`timescale 1ns / 100ps

module matrix_inverse_3x3_test;
  import mi3_pkg::*;

  localparam int N_RANDOM = 730;
  localparam int LATENCY  = PIPE_DEPTH + 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  mi3_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mi3_out_t out_data;
  int       err_count, pending;
  bit       calm = 1'b0;
  bit       sending_done = 1'b0;

  always #6 clk = ~clk;

  matrix_inverse_3x3 i_dut (.*);

  mi3_checker i_checker (.*);

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1: return 16'($signed($urandom_range(0, 1024)) - 512);
      2: return $urandom_range(0, 3) == 0 ? 16'h0000 : 16'h0100;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic mi3_in_t rand_matrix();
    mi3_in_t m;
    m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
         rand_entry(), rand_entry(), rand_entry(), rand_entry()};
    // some singular ones: copy a row
    if ($urandom_range(0, 9) == 0) begin
      m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
    end
    return m;
  endfunction

  // valid drops only for an idle burst, so back-to-back calls keep it high
  task automatic send_matrix(mi3_in_t m);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (!in_ready);
  endtask

  // receiver: random stalls, one long hold-off early on
  initial begin
    int hold;
    @(posedge clk iff rst_n);
    repeat (20) @(posedge clk);
    out_ready <= 1'b0;
    for (hold = 0; hold < 3 * PIPE_DEPTH; hold++) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    mi3_in_t d;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: identity, scaled, extremes, singular, overflow
    send_matrix({16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100});
    send_matrix({16'hFF00, 16'h0, 16'h0, 16'h0, 16'h0200, 16'h0, 16'h0, 16'h0, 16'h0080});
    send_matrix('0);
    send_matrix({9{16'h7FFF}});
    send_matrix({9{16'h8000}});
    send_matrix({16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001});
    send_matrix({16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001});
    send_matrix({16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000});
    send_matrix({16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h8000});
    send_matrix({16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'h0600,
                 16'h0700, 16'h0800, 16'h0900});
    send_matrix({16'h0200, 16'h0100, 16'h0, 16'h0100, 16'h0200, 16'h0100,
                 16'h0, 16'h0100, 16'h0200});
    send_matrix({16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0100, 16'h0, 16'h0});
    send_matrix({16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000,
                 16'h1234, 16'hEDCB, 16'h7FFF});
    send_matrix({16'h0003, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100});
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 100) calm = 1'b1;
      d = rand_matrix();
      send_matrix(d);
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // verdict
  initial begin
    wait (sending_done);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (err_count == 0 && !out_valid)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // timeout
  initial begin
    #(12 * 200000);
    $display("DONE: errors detected");
    $finish;
  end
endmodule

[files.f]
+incdir+sv
sv/mi3_pkg.sv
sv/mi3_front.sv
sv/mi3_div_step.sv
sv/mi3_lane.sv
sv/matrix_inverse_3x3.sv
tb/mi3_checker.sv
tb/matrix_inverse_3x3_test.sv
